### rtl/core/fgoal_pkg.sv
package fgoal_pkg;

    localparam logic [1:0] OP_LEADER   = 2'd0;
    localparam logic [1:0] OP_FOLLOWER = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [2:0] REG_OFF_T    = 3'd0;
    localparam logic [2:0] REG_OFF_N    = 3'd1;
    localparam logic [2:0] REG_OFF_B    = 3'd2;
    localparam logic [2:0] REG_START_X  = 3'd3;
    localparam logic [2:0] REG_START_Y  = 3'd4;
    localparam logic [2:0] REG_GAIN     = 3'd5;
    localparam logic [2:0] REG_SPEED    = 3'd6;
    localparam logic [2:0] REG_DEADBAND = 3'd7;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] vel_t;
        logic signed [31:0] vel_n;
        logic signed [31:0] vel_b;
    } t_item;

    typedef struct packed {
        logic signed [31:0] off_t;
        logic signed [31:0] off_n;
        logic signed [31:0] off_b;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic [30:0]        gain;
        logic [30:0]        speed_limit;
        logic [30:0]        deadband;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [15:0] yaw;
    } t_goal;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/fgoal_front.sv
module fgoal_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  fgoal_pkg::t_item  i_item,
    output logic              o_q_valid,
    output fgoal_pkg::t_item  o_q_item,
    input  logic              i_q_pop
);

    fgoal_pkg::t_item r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       r_seen_l;
    logic       r_seen_f;
    logic       acc;
    logic       keep;
    logic       push;
    logic       pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_ent[r_rp];
    assign acc       = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    // Ticks before both sides have reported, and the unused code, are dropped here.
    always_comb begin
        unique case (i_item.op)
            fgoal_pkg::OP_LEADER:   keep = 1'b1;
            fgoal_pkg::OP_FOLLOWER: keep = 1'b1;
            fgoal_pkg::OP_TICK:     keep = r_seen_l && r_seen_f;
            default:                keep = 1'b0;
        endcase
    end

    assign push = acc && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= 2'd0;
            r_seen_l <= 1'b0;
            r_seen_f <= 1'b0;
        end else begin
            if (acc && i_item.op == fgoal_pkg::OP_LEADER) begin
                r_seen_l <= 1'b1;
            end
            if (acc && i_item.op == fgoal_pkg::OP_FOLLOWER) begin
                r_seen_f <= 1'b1;
            end
            if (push) begin
                r_ent[r_wp] <= i_item;
                r_wp        <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### rtl/core/fgoal_div.sv
module fgoal_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic signed [63:0] i_a,
    input  logic [63:0]        i_b,
    output logic               o_done,
    output logic signed [63:0] o_q
);

    // Restoring division of |a| + b/2 by b, one quotient bit per cycle.
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_n;
    logic [63:0] r_rem;
    logic [63:0] r_b;
    logic        r_neg;
    logic [63:0] mag;
    logic [64:0] trial;
    logic        fits;

    assign mag   = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign trial = {r_rem, r_n[63]};
    assign fits  = (trial >= {1'b0, r_b});
    assign o_done = r_done;
    assign o_q    = r_neg ? -$signed(r_n) : $signed(r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_n    <= mag + (i_b >> 1);
                r_rem  <= 64'd0;
                r_b    <= i_b;
                r_neg  <= i_a[63];
                r_cnt  <= 6'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? 64'(trial - {1'b0, r_b}) : trial[63:0];
                r_n   <= {r_n[62:0], fits};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/fgoal_sqrt.sv
module fgoal_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_n,
    output logic        o_done,
    output logic [31:0] o_root
);

    // Digit-by-digit floor root, two radicand bits per cycle.
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_n;
    logic [33:0] r_rem;
    logic [31:0] r_r;
    logic [35:0] rem2;
    logic [35:0] trial;
    logic        fits;

    assign rem2   = {r_rem, r_n[63:62]};
    assign trial  = {2'b00, r_r, 2'b01};
    assign fits   = (rem2 >= trial);
    assign o_done = r_done;
    assign o_root = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_n    <= i_n;
                r_rem  <= 34'd0;
                r_r    <= 32'd0;
                r_cnt  <= 5'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? 34'(rem2 - trial) : rem2[33:0];
                r_r   <= {r_r[30:0], fits};
                r_n   <= {r_n[61:0], 2'b00};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/fgoal_back.sv
module fgoal_back #(
    parameter logic signed [31:0] START_OFFSET_Z = 32'sd0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  fgoal_pkg::t_item  i_q_item,
    output logic              o_q_pop,
    input  fgoal_pkg::t_cfg   i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output fgoal_pkg::t_goal  o_goal
);

    localparam logic signed [31:0] QONE    = 32'sd268435456;
    localparam logic signed [27:0] PI_Q24  = 28'sd52707179;
    localparam logic signed [17:0] YAW_MAX = 18'sd25736;
    localparam logic [1:0] ROT_OFF = 2'd0;
    localparam logic [1:0] ROT_REL = 2'd1;
    localparam logic [1:0] ROT_VEL = 2'd2;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_QMUL  = 11'b00000000010,
        S_MDIV  = 11'b00000000100,
        S_ROT   = 11'b00000001000,
        S_ERR   = 11'b00000010000,
        S_NORM  = 11'b00000100000,
        S_SCALE = 11'b00001000000,
        S_YAW   = 11'b00010000000,
        S_CORD  = 11'b00100000000,
        S_YFIN  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    function automatic logic [24:0] atan_q24(input logic [4:0] i);
        logic [24:0] r;
        unique case (i)
            5'd0:  r = 25'd13176795;
            5'd1:  r = 25'd7778716;
            5'd2:  r = 25'd4110060;
            5'd3:  r = 25'd2086331;
            5'd4:  r = 25'd1047214;
            5'd5:  r = 25'd524117;
            5'd6:  r = 25'd262123;
            5'd7:  r = 25'd131069;
            default: r = 25'd1 << (5'd24 - i);
        endcase
        return r;
    endfunction

    function automatic logic signed [37:0] rnd28(input logic signed [63:0] v);
        logic [63:0]        mag;
        logic [63:0]        q;
        logic signed [37:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        q   = (mag + 64'd134217728) >> 28;
        r   = 38'(q);
        return v[63] ? -r : r;
    endfunction

    t_state r_state;
    logic   r_ph;
    logic [3:0] r_k;
    logic [1:0] r_i;
    logic [1:0] r_j;
    logic [1:0] r_rsel;
    logic [4:0] r_ci;

    logic signed [31:0] r_lp [3];
    logic signed [15:0] r_q  [4];
    logic signed [31:0] r_lv [3];
    logic signed [31:0] r_fp [3];
    logic signed [31:0] r_pq [10];
    logic signed [31:0] r_m  [9];
    logic signed [37:0] r_rt [3];
    logic signed [31:0] r_u  [3];
    logic signed [31:0] r_gp [3];
    logic signed [31:0] r_gv [3];
    logic signed [15:0] r_yaw;

    logic signed [63:0] r_acc;
    logic signed [63:0] r_mp;
    logic [63:0]        r_sum;
    logic signed [31:0] r_s;
    logic [31:0]        r_d;
    logic [31:0]        r_norm;
    logic signed [32:0] r_term;
    logic signed [39:0] r_cx;
    logic signed [39:0] r_cy;
    logic signed [27:0] r_cz;

    logic             r_ovld;
    fgoal_pkg::t_goal r_out;

    logic signed [31:0] offs [3];
    logic signed [31:0] st   [3];
    logic signed [34:0] rel  [3];
    logic signed [34:0] num  [9];
    logic [32:0]        n2;
    logic [1:0]         qa;
    logic [1:0]         qb;
    logic [3:0]         m_idx;
    logic signed [34:0] ma;
    logic signed [34:0] mb;
    logic signed [69:0] mul_p;
    logic signed [63:0] acc_n;
    logic signed [37:0] rd;
    logic signed [39:0] e;
    logic signed [39:0] db40;
    logic signed [31:0] s_n;
    logic               div_go;
    logic signed [63:0] div_a;
    logic [63:0]        div_b;
    logic               div_done;
    logic signed [63:0] div_q;
    logic               sqrt_go;
    logic [63:0]        sqrt_n;
    logic               sqrt_done;
    logic [31:0]        sqrt_r;
    logic signed [35:0] ya;
    logic signed [35:0] yb;
    logic signed [39:0] dx;
    logic signed [39:0] dy;
    logic signed [27:0] atv;
    logic [27:0]        zmag;
    logic signed [17:0] zr;

    assign offs[0] = i_cfg.off_t;
    assign offs[1] = i_cfg.off_n;
    assign offs[2] = i_cfg.off_b;
    assign st[0]   = i_cfg.start_x;
    assign st[1]   = i_cfg.start_y;
    assign st[2]   = START_OFFSET_Z;

    for (genvar g = 0; g < 3; g++) begin : g_rel
        assign rel[g] = 35'(r_fp[g]) + 35'(st[g]) - 35'(r_lp[g]);
    end

    // Product slots: 0 ww, 1 xx, 2 yy, 3 zz, 4 xy, 5 wz, 6 xz, 7 wy, 8 yz, 9 wx.
    assign n2 = 33'(r_pq[0]) + 33'(r_pq[1]) + 33'(r_pq[2]) + 33'(r_pq[3]);
    assign num[0] = 35'(r_pq[0]) + 35'(r_pq[1]) - 35'(r_pq[2]) - 35'(r_pq[3]);
    assign num[1] = (35'(r_pq[4]) - 35'(r_pq[5])) <<< 1;
    assign num[2] = (35'(r_pq[6]) + 35'(r_pq[7])) <<< 1;
    assign num[3] = (35'(r_pq[4]) + 35'(r_pq[5])) <<< 1;
    assign num[4] = 35'(r_pq[0]) - 35'(r_pq[1]) + 35'(r_pq[2]) - 35'(r_pq[3]);
    assign num[5] = (35'(r_pq[8]) - 35'(r_pq[9])) <<< 1;
    assign num[6] = (35'(r_pq[6]) - 35'(r_pq[7])) <<< 1;
    assign num[7] = (35'(r_pq[8]) + 35'(r_pq[9])) <<< 1;
    assign num[8] = 35'(r_pq[0]) - 35'(r_pq[1]) - 35'(r_pq[2]) + 35'(r_pq[3]);

    assign ya = (36'(r_pq[5]) + 36'(r_pq[4])) <<< 1;
    assign yb = 36'(QONE) - ((36'(r_pq[2]) + 36'(r_pq[3])) <<< 1);

    always_comb begin
        unique case (r_k)
            4'd0:    begin qa = 2'd0; qb = 2'd0; end
            4'd1:    begin qa = 2'd1; qb = 2'd1; end
            4'd2:    begin qa = 2'd2; qb = 2'd2; end
            4'd3:    begin qa = 2'd3; qb = 2'd3; end
            4'd4:    begin qa = 2'd1; qb = 2'd2; end
            4'd5:    begin qa = 2'd0; qb = 2'd3; end
            4'd6:    begin qa = 2'd1; qb = 2'd3; end
            4'd7:    begin qa = 2'd0; qb = 2'd2; end
            4'd8:    begin qa = 2'd2; qb = 2'd3; end
            default: begin qa = 2'd0; qb = 2'd1; end
        endcase
    end

    // The relative-position pass uses the transpose of the rotation.
    always_comb begin
        if (r_rsel == ROT_REL) begin
            m_idx = {2'b00, r_j} + {2'b00, r_j} + {2'b00, r_j} + {2'b00, r_i};
        end else begin
            m_idx = {2'b00, r_i} + {2'b00, r_i} + {2'b00, r_i} + {2'b00, r_j};
        end
    end

    always_comb begin
        ma = 35'sd0;
        mb = 35'sd0;
        priority case (1'b1)
            r_state == S_QMUL: begin
                ma = 35'(r_q[qa]);
                mb = 35'(r_q[qb]);
            end
            r_state == S_ROT: begin
                ma = 35'(r_m[m_idx]);
                if (r_rsel == ROT_OFF) begin
                    mb = 35'(offs[r_j]);
                end else if (r_rsel == ROT_REL) begin
                    mb = rel[r_j];
                end else begin
                    mb = 35'(r_u[r_j]);
                end
            end
            r_state == S_ERR: begin
                if (r_k == 4'd2) begin
                    ma = 35'sd0 + 35'(i_cfg.gain);
                    mb = 35'sd0 + 35'(i_cfg.gain);
                end else if (r_k == 4'd3) begin
                    ma = 35'(r_s);
                    mb = 35'sd0 + 35'(i_cfg.speed_limit);
                end else begin
                    ma = 35'(r_s);
                    mb = 35'(r_s);
                end
            end
            r_state == S_NORM: begin
                ma = 35'(r_u[r_k[1:0]]);
                mb = 35'(r_u[r_k[1:0]]);
            end
            r_state == S_SCALE: begin
                ma = 35'(r_u[r_i]);
                mb = 35'sd0 + 35'(i_cfg.speed_limit);
            end
            default: begin
                ma = 35'sd0;
                mb = 35'sd0;
            end
        endcase
    end

    assign mul_p = ma * mb;
    assign acc_n = ((r_j == 2'd0) ? 64'sd0 : r_acc) + r_mp;
    assign rd    = rnd28(acc_n);

    assign e    = 40'(offs[r_i]) - 40'(r_rt[r_i]);
    assign db40 = 40'sd0 + 40'(i_cfg.deadband);
    assign s_n  = (e < db40 && e > -db40) ? 32'sd0 : fgoal_pkg::sat32(e);

    always_comb begin
        div_go = 1'b0;
        div_a  = r_mp;
        div_b  = {32'd0, r_d};
        if (r_state == S_MDIV) begin
            div_go = !r_ph && (n2 != 33'd0);
            div_a  = 64'(num[r_k]) <<< 28;
            div_b  = {31'd0, n2};
        end else if (r_state == S_ERR) begin
            div_go = (r_k == 4'd5) && (r_d != 32'd0);
        end else if (r_state == S_SCALE) begin
            div_go = (r_k == 4'd1);
            div_b  = {32'd0, r_norm};
        end
    end

    assign sqrt_go = (r_state == S_ERR || r_state == S_NORM) && (r_k == 4'd3);
    assign sqrt_n  = r_sum + 64'(r_mp);

    assign dx   = r_cy >>> r_ci;
    assign dy   = r_cx >>> r_ci;
    assign atv  = $signed({3'b000, atan_q24(r_ci)});
    assign zmag = r_cz[27] ? 28'(-r_cz) : 28'(r_cz);
    assign zr   = r_cz[27] ? -$signed(18'((zmag + 28'd1024) >> 11))
                           : $signed(18'((zmag + 28'd1024) >> 11));

    fgoal_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (div_go),
        .i_a     (div_a),
        .i_b     (div_b),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    fgoal_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (sqrt_go),
        .i_n     (sqrt_n),
        .o_done  (sqrt_done),
        .o_root  (sqrt_r)
    );

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_ovld;
    assign o_goal  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_k     <= 4'd0;
            r_i     <= 2'd0;
            r_j     <= 2'd0;
            r_rsel  <= ROT_OFF;
            r_ci    <= 5'd0;
            r_ovld  <= 1'b0;
        end else begin
            if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_item.op == fgoal_pkg::OP_LEADER) begin
                            r_lp[0] <= i_q_item.pos_x;
                            r_lp[1] <= i_q_item.pos_y;
                            r_lp[2] <= i_q_item.pos_z;
                            r_q[0]  <= i_q_item.quat_w;
                            r_q[1]  <= i_q_item.quat_x;
                            r_q[2]  <= i_q_item.quat_y;
                            r_q[3]  <= i_q_item.quat_z;
                            r_lv[0] <= i_q_item.vel_t;
                            r_lv[1] <= i_q_item.vel_n;
                            r_lv[2] <= i_q_item.vel_b;
                        end else if (i_q_item.op == fgoal_pkg::OP_FOLLOWER) begin
                            r_fp[0] <= i_q_item.pos_x;
                            r_fp[1] <= i_q_item.pos_y;
                            r_fp[2] <= i_q_item.pos_z;
                        end else if (i_q_item.op == fgoal_pkg::OP_TICK) begin
                            r_state <= S_QMUL;
                            r_k     <= 4'd0;
                            r_ph    <= 1'b0;
                        end
                    end
                end
                S_QMUL: begin
                    if (!r_ph) begin
                        r_mp <= mul_p[63:0];
                        r_ph <= 1'b1;
                    end else begin
                        r_pq[r_k] <= r_mp[31:0];
                        r_ph      <= 1'b0;
                        if (r_k == 4'd9) begin
                            r_k     <= 4'd0;
                            r_state <= S_MDIV;
                        end else begin
                            r_k <= r_k + 4'd1;
                        end
                    end
                end
                S_MDIV: begin
                    if (n2 == 33'd0) begin
                        // A zero quaternion leaves the rotation at identity.
                        for (int t = 0; t < 9; t++) begin
                            r_m[t] <= (t % 4 == 0) ? QONE : 32'sd0;
                        end
                        r_state <= S_ROT;
                        r_rsel  <= ROT_OFF;
                        r_i     <= 2'd0;
                        r_j     <= 2'd0;
                    end else if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (div_done) begin
                        r_m[r_k] <= div_q[31:0];
                        r_ph     <= 1'b0;
                        if (r_k == 4'd8) begin
                            r_state <= S_ROT;
                            r_rsel  <= ROT_OFF;
                            r_i     <= 2'd0;
                            r_j     <= 2'd0;
                        end else begin
                            r_k <= r_k + 4'd1;
                        end
                    end
                end
                S_ROT: begin
                    if (!r_ph) begin
                        r_mp <= mul_p[63:0];
                        r_ph <= 1'b1;
                    end else begin
                        r_acc <= acc_n;
                        r_ph  <= 1'b0;
                        if (r_j == 2'd2) begin
                            r_j <= 2'd0;
                            if (r_rsel == ROT_OFF) begin
                                r_gp[r_i] <= fgoal_pkg::sat32(40'(r_lp[r_i]) + 40'(rd)
                                                              - 40'(st[r_i]));
                            end else if (r_rsel == ROT_REL) begin
                                r_rt[r_i] <= rd;
                            end else begin
                                r_gv[r_i] <= fgoal_pkg::sat32(40'(rd));
                            end
                            if (r_i == 2'd2) begin
                                r_i <= 2'd0;
                                if (r_rsel == ROT_OFF) begin
                                    r_rsel <= ROT_REL;
                                end else if (r_rsel == ROT_REL) begin
                                    r_state <= S_ERR;
                                    r_k     <= 4'd0;
                                end else begin
                                    r_state <= S_YAW;
                                end
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                end
                S_ERR: begin
                    unique case (r_k)
                        4'd0: begin
                            r_s <= s_n;
                            r_k <= 4'd1;
                        end
                        4'd1: begin
                            r_mp <= mul_p[63:0];
                            r_k  <= 4'd2;
                        end
                        4'd2: begin
                            r_sum <= 64'(r_mp);
                            r_mp  <= mul_p[63:0];
                            r_k   <= 4'd3;
                        end
                        4'd3: begin
                            r_mp <= mul_p[63:0];
                            r_k  <= 4'd4;
                        end
                        4'd4: begin
                            if (sqrt_done) begin
                                r_d <= sqrt_r;
                                r_k <= 4'd5;
                            end
                        end
                        4'd5: begin
                            if (r_d == 32'd0) begin
                                r_term <= 33'sd0;
                                r_k    <= 4'd7;
                            end else begin
                                r_k <= 4'd6;
                            end
                        end
                        4'd6: begin
                            if (div_done) begin
                                r_term <= div_q[32:0];
                                r_k    <= 4'd7;
                            end
                        end
                        default: begin
                            r_u[r_i] <= fgoal_pkg::sat32(40'(r_lv[r_i]) + 40'(r_term));
                            r_k      <= 4'd0;
                            if (r_i == 2'd2) begin
                                r_i     <= 2'd0;
                                r_state <= S_NORM;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end
                    endcase
                end
                S_NORM: begin
                    unique case (r_k)
                        4'd0: begin
                            r_mp <= mul_p[63:0];
                            r_k  <= 4'd1;
                        end
                        4'd1: begin
                            r_sum <= 64'(r_mp);
                            r_mp  <= mul_p[63:0];
                            r_k   <= 4'd2;
                        end
                        4'd2: begin
                            r_sum <= r_sum + 64'(r_mp);
                            r_mp  <= mul_p[63:0];
                            r_k   <= 4'd3;
                        end
                        4'd3: begin
                            r_k <= 4'd4;
                        end
                        default: begin
                            if (sqrt_done) begin
                                r_norm <= sqrt_r;
                                r_k    <= 4'd0;
                                r_i    <= 2'd0;
                                r_j    <= 2'd0;
                                if (sqrt_r > {1'b0, i_cfg.speed_limit}) begin
                                    r_state <= S_SCALE;
                                end else begin
                                    r_state <= S_ROT;
                                    r_rsel  <= ROT_VEL;
                                end
                            end
                        end
                    endcase
                end
                S_SCALE: begin
                    if (r_k == 4'd0) begin
                        r_mp <= mul_p[63:0];
                        r_k  <= 4'd1;
                    end else if (r_k == 4'd1) begin
                        r_k <= 4'd2;
                    end else if (div_done) begin
                        r_u[r_i] <= div_q[31:0];
                        r_k      <= 4'd0;
                        if (r_i == 2'd2) begin
                            r_i     <= 2'd0;
                            r_j     <= 2'd0;
                            r_state <= S_ROT;
                            r_rsel  <= ROT_VEL;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end
                end
                S_YAW: begin
                    r_ci <= 5'd0;
                    if (ya == 36'sd0) begin
                        r_yaw   <= yb[35] ? 16'(YAW_MAX) : 16'sd0;
                        r_state <= S_OUT;
                    end else begin
                        // Fold the left half-plane over by a half turn first.
                        if (yb[35]) begin
                            r_cx <= -40'(yb);
                            r_cy <= -40'(ya);
                            r_cz <= ya[35] ? -PI_Q24 : PI_Q24;
                        end else begin
                            r_cx <= 40'(yb);
                            r_cy <= 40'(ya);
                            r_cz <= 28'sd0;
                        end
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (!r_cy[39]) begin
                        r_cx <= r_cx + dx;
                        r_cy <= r_cy - dy;
                        r_cz <= r_cz + atv;
                    end else begin
                        r_cx <= r_cx - dx;
                        r_cy <= r_cy + dy;
                        r_cz <= r_cz - atv;
                    end
                    if (r_ci == 5'd24) begin
                        r_state <= S_YFIN;
                    end else begin
                        r_ci <= r_ci + 5'd1;
                    end
                end
                S_YFIN: begin
                    if (zr > YAW_MAX) begin
                        r_yaw <= 16'(YAW_MAX);
                    end else if (zr < -YAW_MAX) begin
                        r_yaw <= 16'(-YAW_MAX);
                    end else begin
                        r_yaw <= zr[15:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovld) begin
                        r_out.px  <= r_gp[0];
                        r_out.py  <= r_gp[1];
                        r_out.pz  <= r_gp[2];
                        r_out.vx  <= r_gv[0];
                        r_out.vy  <= r_gv[1];
                        r_out.vz  <= r_gv[2];
                        r_out.yaw <= r_yaw;
                        r_ovld    <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/formation_follower_goal_core.sv
// Leader-follower formation goal generator. Items on the input stream are leader updates,
// follower updates or ticks; only a tick, once both a leader and a follower update have
// been seen, produces one goal on the output stream. Updates and kept ticks are taken into
// a two-entry queue. A tick runs on a shared sequencer with one 35x35 multiplier, a 64-step
// divider and a 32-step square root: nine divisions build the rotation matrix, each axis
// needs one root and at most one division, the speed clamp adds a root and up to three
// divisions, and the yaw takes a 25-step CORDIC. A zero quaternion skips the matrix
// divisions and the CORDIC. The finished goal waits in an output register, so the next
// tick can start while it is still unclaimed.
module formation_follower_goal_core #(
    parameter logic signed [31:0] START_OFFSET_Z = 32'sd0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, vel_t, vel_n, vel_b
    input  logic [255:0] i_s_axis_tdata,
    // op
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // goal_px, goal_py, goal_pz, goal_vx, goal_vy, goal_vz, goal_yaw
    output logic [207:0] o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata
);

    fgoal_pkg::t_cfg  r_cfg;
    fgoal_pkg::t_item in_item;
    fgoal_pkg::t_item q_item;
    fgoal_pkg::t_goal goal;
    logic             q_valid;
    logic             q_pop;

    assign in_item.op     = i_s_axis_tuser;
    assign in_item.pos_x  = i_s_axis_tdata[31:0];
    assign in_item.pos_y  = i_s_axis_tdata[63:32];
    assign in_item.pos_z  = i_s_axis_tdata[95:64];
    assign in_item.quat_w = i_s_axis_tdata[111:96];
    assign in_item.quat_x = i_s_axis_tdata[127:112];
    assign in_item.quat_y = i_s_axis_tdata[143:128];
    assign in_item.quat_z = i_s_axis_tdata[159:144];
    assign in_item.vel_t  = i_s_axis_tdata[191:160];
    assign in_item.vel_n  = i_s_axis_tdata[223:192];
    assign in_item.vel_b  = i_s_axis_tdata[255:224];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.off_t       <= 32'sd0;
            r_cfg.off_n       <= 32'sd0;
            r_cfg.off_b       <= 32'sd0;
            r_cfg.start_x     <= 32'sd0;
            r_cfg.start_y     <= 32'sd196608;
            r_cfg.gain        <= 31'd655;
            r_cfg.speed_limit <= 31'd131072;
            r_cfg.deadband    <= 31'd3277;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fgoal_pkg::REG_OFF_T:    r_cfg.off_t       <= i_cfg_wdata;
                fgoal_pkg::REG_OFF_N:    r_cfg.off_n       <= i_cfg_wdata;
                fgoal_pkg::REG_OFF_B:    r_cfg.off_b       <= i_cfg_wdata;
                fgoal_pkg::REG_START_X:  r_cfg.start_x     <= i_cfg_wdata;
                fgoal_pkg::REG_START_Y:  r_cfg.start_y     <= i_cfg_wdata;
                fgoal_pkg::REG_GAIN:     r_cfg.gain        <= i_cfg_wdata[30:0];
                fgoal_pkg::REG_SPEED:    r_cfg.speed_limit <= i_cfg_wdata[30:0];
                fgoal_pkg::REG_DEADBAND: r_cfg.deadband    <= i_cfg_wdata[30:0];
                default:                 r_cfg.deadband    <= r_cfg.deadband;
            endcase
        end
    end

    fgoal_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    fgoal_back #(
        .START_OFFSET_Z (START_OFFSET_Z)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .i_cfg     (r_cfg),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_goal    (goal)
    );

    assign o_m_axis_tdata = {goal.yaw, goal.vz, goal.vy, goal.vx, goal.pz, goal.py, goal.px};

endmodule

### test/tb_formation_follower_goal_core.sv
`timescale 1ns / 100ps

module tb_formation_follower_goal_core;

    localparam longint QONE = 64'sd268435456;
    localparam longint PI_Q24 = 64'sd52707179;
    localparam longint YAW_LIM = 64'sd25736;
    localparam int DRAIN_CYCLES = 1400;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic [1:0]   s_tuser = fgoal_pkg::OP_LEADER;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_idx = fgoal_pkg::REG_OFF_T;
    logic [31:0]  cfg_wdata = '0;

    formation_follower_goal_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Model state of the goal generator.
    fgoal_pkg::t_cfg  cfg_now;
    longint ldr_pos[3], ldr_vel[3], fol_pos[3], ldr_q[4];
    bit     ldr_seen, fol_seen;
    fgoal_pkg::t_goal goal_fifo[$];

    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    int items_sent = 0;
    int goals_seen = 0;
    int ticks_sent = 0;

    longint cordic_atan[25] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
        262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2, 1};

    function automatic longint div_round(longint a, longint b);
        longint unsigned ua, q;
        ua = (a < 0) ? longint'(0) - a : a;
        q = (ua + longint'(longint'(b) / 2)) / longint'(b);
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void rotate_vec(input longint m[3][3], input longint v[3],
                                       input bit transpose, output longint o[3]);
        longint acc;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += (transpose ? m[j][i] : m[i][j]) * v[j];
            o[i] = div_round(acc, QONE);
        end
    endfunction

    function automatic longint leader_yaw(longint a, longint b);
        longint x, y, z, dx, dy;
        x = b;
        y = a;
        z = 0;
        if (a == 0) return (b < 0) ? YAW_LIM : 0;
        if (x < 0) begin
            z = (y >= 0) ? PI_Q24 : -PI_Q24;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 25; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += cordic_atan[i];
            end else begin
                x -= dx; y += dy; z -= cordic_atan[i];
            end
        end
        z = div_round(z, 2048);
        if (z > YAW_LIM) z = YAW_LIM;
        if (z < -YAW_LIM) z = -YAW_LIM;
        return z;
    endfunction

    // Updates the model with one accepted item and queues the goal it causes.
    function automatic void predict_goal(input fgoal_pkg::t_item it);
        longint m[3][3], num[3][3], off[3], st[3], ro[3], rel[3], rt[3], u[3], vw[3];
        longint w, x, y, z, n2, umax, p, db, e, s, term, norm;
        longint unsigned d, sumsq;
        fgoal_pkg::t_goal g;
        if (it.op == fgoal_pkg::OP_LEADER) begin
            ldr_pos = '{it.pos_x, it.pos_y, it.pos_z};
            ldr_vel = '{it.vel_t, it.vel_n, it.vel_b};
            ldr_q = '{it.quat_w, it.quat_x, it.quat_y, it.quat_z};
            ldr_seen = 1;
            return;
        end
        if (it.op == fgoal_pkg::OP_FOLLOWER) begin
            fol_pos = '{it.pos_x, it.pos_y, it.pos_z};
            fol_seen = 1;
            return;
        end
        if (it.op != fgoal_pkg::OP_TICK || !ldr_seen || !fol_seen) return;
        w = ldr_q[0]; x = ldr_q[1]; y = ldr_q[2]; z = ldr_q[3];
        n2 = w * w + x * x + y * y + z * z;
        num = '{'{w * w + x * x - y * y - z * z, 2 * (x * y - w * z), 2 * (x * z + w * y)},
                '{2 * (x * y + w * z), w * w - x * x + y * y - z * z, 2 * (y * z - w * x)},
                '{2 * (x * z - w * y), 2 * (y * z + w * x), w * w - x * x - y * y + z * z}};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = (n2 == 0) ? ((i == j) ? QONE : 0) : div_round(num[i][j] * QONE, n2);
        off = '{cfg_now.off_t, cfg_now.off_n, cfg_now.off_b};
        st = '{cfg_now.start_x, cfg_now.start_y, 0};
        p = longint'(cfg_now.gain);
        umax = longint'(cfg_now.speed_limit);
        db = longint'(cfg_now.deadband);
        rotate_vec(m, off, 1'b0, ro);
        for (int i = 0; i < 3; i++)
            rel[i] = fol_pos[i] + st[i] - ldr_pos[i];
        rotate_vec(m, rel, 1'b1, rt);
        g.px = 32'(clip32(ldr_pos[0] + ro[0] - st[0]));
        g.py = 32'(clip32(ldr_pos[1] + ro[1] - st[1]));
        g.pz = 32'(clip32(ldr_pos[2] + ro[2] - st[2]));
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
            e = off[i] - rt[i];
            s = (e < db && e > -db) ? 0 : clip32(e);
            d = int_sqrt(longint'(s * s) + longint'(p * p));
            term = (d != 0) ? div_round(umax * s, longint'(d)) : 0;
            u[i] = clip32(ldr_vel[i] + term);
            sumsq += longint'(u[i] * u[i]);
        end
        norm = longint'(int_sqrt(sumsq));
        if (norm > umax)
            for (int i = 0; i < 3; i++) u[i] = div_round(u[i] * umax, norm);
        rotate_vec(m, u, 1'b0, vw);
        g.vx = 32'(clip32(vw[0]));
        g.vy = 32'(clip32(vw[1]));
        g.vz = 32'(clip32(vw[2]));
        g.yaw = 16'(leader_yaw(2 * (w * z + x * y), QONE - 2 * (y * y + z * z)));
        goal_fifo.push_back(g);
    endfunction

    // Output side: random back-pressure and a compare on every transfer.
    always @(posedge i_clk) begin
        fgoal_pkg::t_goal got, exp_goal;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
            if (m_tvalid === 1'b1 && m_tready) begin
                got.px = m_tdata[31:0];
                got.py = m_tdata[63:32];
                got.pz = m_tdata[95:64];
                got.vx = m_tdata[127:96];
                got.vy = m_tdata[159:128];
                got.vz = m_tdata[191:160];
                got.yaw = m_tdata[207:192];
                goals_seen++;
                if (goal_fifo.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected goal transfer: %p", got);
                end else begin
                    exp_goal = goal_fifo.pop_front();
                    if (got.px !== exp_goal.px || got.py !== exp_goal.py
                            || got.pz !== exp_goal.pz || got.vx !== exp_goal.vx
                            || got.vy !== exp_goal.vy || got.vz !== exp_goal.vz
                            || got.yaw !== exp_goal.yaw) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("goal mismatch: expected %p, got %p", exp_goal, got);
                    end
                end
            end
        end
    end

    task automatic send_item(input fgoal_pkg::t_item it);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {it.vel_b, it.vel_n, it.vel_t, it.quat_z, it.quat_y, it.quat_x,
                    it.quat_w, it.pos_z, it.pos_y, it.pos_x};
        do @(posedge i_clk); while (!s_tready);
        predict_goal(it);
        items_sent++;
        if (it.op == fgoal_pkg::OP_TICK) ticks_sent++;
    endtask

    // Idles the input, waits for every goal, then lets the sequencer finish.
    task automatic drain_goals();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (goal_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_cfg(input fgoal_pkg::t_cfg c);
        logic [31:0] vals[8];
        vals = '{c.off_t, c.off_n, c.off_b, c.start_x, c.start_y,
                 {1'b0, c.gain}, {1'b0, c.speed_limit}, {1'b0, c.deadband}};
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= i[2:0];
            cfg_wdata <= vals[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        cfg_now = c;
    endtask

    function automatic logic [31:0] rand_q16();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0) return $urandom;
        if (sel == 1) return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
        return $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
    endfunction

    function automatic logic [15:0] rand_quat();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel == 0) return 16'($urandom);
        if (sel == 1) return 16'd0;
        return 16'($urandom_range(0, 32767) - 16384);
    endfunction

    function automatic fgoal_pkg::t_item make_item(input logic [1:0] op);
        fgoal_pkg::t_item it;
        it.op = op;
        it.pos_x = rand_q16(); it.pos_y = rand_q16(); it.pos_z = rand_q16();
        it.quat_w = rand_quat(); it.quat_x = rand_quat();
        it.quat_y = rand_quat(); it.quat_z = rand_quat();
        it.vel_t = rand_q16(); it.vel_n = rand_q16(); it.vel_b = rand_q16();
        return it;
    endfunction

    function automatic fgoal_pkg::t_item quat_item(input logic [15:0] qw, qx, qy, qz);
        fgoal_pkg::t_item it;
        it = make_item(fgoal_pkg::OP_LEADER);
        it.quat_w = qw; it.quat_x = qx; it.quat_y = qy; it.quat_z = qz;
        return it;
    endfunction

    function automatic fgoal_pkg::t_cfg rand_cfg();
        fgoal_pkg::t_cfg c;
        c.off_t = rand_q16(); c.off_n = rand_q16(); c.off_b = rand_q16();
        c.start_x = rand_q16(); c.start_y = rand_q16();
        c.gain = 31'($urandom_range(1, 32'h0004_0000));
        c.speed_limit = 31'($urandom_range(0, 32'h0010_0000));
        c.deadband = 31'($urandom_range(0, 32'h0002_0000));
        return c;
    endfunction

    // Early ticks and an unused op give no goal; the tick after both updates gives one.
    task automatic test_ticks_before_updates();
        fgoal_pkg::t_item it;
        it = make_item(fgoal_pkg::OP_TICK);
        send_item(it);
        it = make_item(2'd3);
        send_item(it);
        send_item(make_item(fgoal_pkg::OP_LEADER));
        send_item(make_item(fgoal_pkg::OP_TICK));
        send_item(make_item(fgoal_pkg::OP_FOLLOWER));
        send_item(make_item(fgoal_pkg::OP_TICK));
        drain_goals();
    endtask

    // Zero quaternion, yaw on the axis, saturating errors and velocities, and extreme register settings.
    task automatic test_directed_cases();
        fgoal_pkg::t_item it;
        fgoal_pkg::t_cfg c;
        send_item(quat_item(16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(fgoal_pkg::OP_TICK));
        send_item(quat_item(16'd0, 16'd0, 16'sd16384, 16'd0));
        send_item(make_item(fgoal_pkg::OP_TICK));
        send_item(quat_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        send_item(make_item(fgoal_pkg::OP_TICK));
        it = quat_item(16'sd16384, 16'd0, 16'd0, 16'd0);
        it.pos_x = 32'h80000000; it.pos_y = 32'h80000000; it.pos_z = 32'h80000000;
        it.vel_t = 32'h7FFFFFFF; it.vel_n = 32'h80000000; it.vel_b = 32'h7FFFFFFF;
        send_item(it);
        it = make_item(fgoal_pkg::OP_FOLLOWER);
        it.pos_x = 32'h7FFFFFFF; it.pos_y = 32'h7FFFFFFF; it.pos_z = 32'h7FFFFFFF;
        send_item(it);
        send_item(make_item(fgoal_pkg::OP_TICK));
        send_item(make_item(2'd3));
        drain_goals();
        c = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              31'd1, 31'h7FFFFFFF, 31'd0};
        apply_cfg(c);
        send_item(make_item(fgoal_pkg::OP_TICK));
        send_item(quat_item(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_item(make_item(fgoal_pkg::OP_TICK));
        drain_goals();
        c = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              31'h7FFFFFFF, 31'd0, 31'h7FFFFFFF};
        apply_cfg(c);
        send_item(make_item(fgoal_pkg::OP_TICK));
        send_item(make_item(fgoal_pkg::OP_FOLLOWER));
        send_item(make_item(fgoal_pkg::OP_TICK));
        drain_goals();
    endtask

    task automatic test_random_phase(input int count, input int s_idle, input int r_idle);
        int unsigned r;
        send_idle = s_idle;
        recv_idle = r_idle;
        apply_cfg(rand_cfg());
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 30) send_item(make_item(fgoal_pkg::OP_LEADER));
            else if (r < 60) send_item(make_item(fgoal_pkg::OP_FOLLOWER));
            else if (r < 96) send_item(make_item(fgoal_pkg::OP_TICK));
            else send_item(make_item(2'd3));
        end
        drain_goals();
    endtask

    initial begin
        cfg_now = '{0, 0, 0, 0, 196608, 31'd655, 31'd131072, 31'd3277};
        ldr_seen = 0;
        fol_seen = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ticks_before_updates();
        test_directed_cases();
        test_random_phase(520, 28, 81);
        test_random_phase(520, 81, 28);
        test_random_phase(520, 0, 0);
        $display("Sent %0d items including %0d ticks; checked %0d goals", items_sent,
                 ticks_sent, goals_seen);
        $display("over default, extreme and random register settings and three idle mixes.");
        if (mismatches == 0 && goal_fifo.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(64'd400_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
